// File: rtl/core/crws_pkg.sv
package crws_pkg;

   // Field and register widths.
   localparam int X_W        = 41;
   localparam int Y_W        = 12;
   localparam int STEP_W     = 40;
   localparam int THR_W      = 54;
   localparam int CW_W       = Y_W + 1;
   localparam int WORD_W     = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 54;

   // Stream payload layout.
   localparam int REQ_TDATA_W  = 64;
   localparam int RSP_FIELDS_W = X_W + Y_W + STEP_W + WORD_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QP_W        = $clog2(QUEUE_DEPTH);

   // Mixing and hashing constants.
   localparam logic [WORD_W-1:0] M_A       = 64'hff51afd7ed558ccd;
   localparam logic [WORD_W-1:0] M_B       = 64'hc4ceb9fe1a85ec53;
   localparam logic [WORD_W-1:0] GOLD      = 64'h9E3779B97F4A7C15;
   localparam logic [WORD_W-1:0] YMUL      = 64'hC2B2AE3D27D4EB4F;
   localparam logic [WORD_W-1:0] SEED_SALT = 64'h5851F42D4C957F2D;
   localparam logic [WORD_W-1:0] DIS_SALT  = 64'hA24BAED4963EE407;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_THR_RIGHT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_LEFT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_UP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAN_WIDTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOUNDARY   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LIMIT = 3'd5;

   // Register reset values.
   localparam logic [THR_W-1:0]  THR_RIGHT_RST  = 54'd3602879701896397;
   localparam logic [THR_W-1:0]  THR_LEFT_RST   = 54'd7205759403792794;
   localparam logic [THR_W-1:0]  THR_UP_RST     = 54'd8106479329266893;
   localparam logic [CW_W-1:0]   CHAN_WIDTH_RST = 13'd5;
   localparam logic [STEP_W-1:0] STEP_LIMIT_RST = 40'd2000000000;

   // Input opcode carried on tuser.
   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [THR_W-1:0]  thr_right;
      logic [THR_W-1:0]  thr_left;
      logic [THR_W-1:0]  thr_up;
      logic [CW_W-1:0]   chan_width;
      logic              reflect;
      logic [STEP_W-1:0] step_limit;
   } cfg_type;

   // One classified item waiting in the queue.
   typedef struct packed {
      logic              is_start;
      logic [WORD_W-1:0] seed;
   } item_type;

   typedef struct packed {
      logic              go;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic signed [X_W-1:0] x;
      logic [Y_W-1:0]        y;
      logic [STEP_W-1:0]     steps;
      logic [WORD_W-1:0]     hash;
      logic                  capped;
   } result_type;

endpackage

// File: rtl/core/crws_mul.sv
// Shared 64 by 64 multiplier that keeps the low 64 bits of the product.
// It forms one 32 by 32 partial product per cycle: low times low, then the
// two cross terms into the upper half. The operands must hold while busy.
module crws_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  crws_pkg::mul_req_type req,
   output crws_pkg::mul_rsp_type rsp
);

   logic [1:0]                     cnt_ff;
   logic                           busy_ff;
   logic                           done_ff;
   logic [crws_pkg::WORD_W-1:0]    acc_ff;
   logic [31:0]                    op_x;
   logic [31:0]                    op_y;
   logic [63:0]                    part;

   // Operand halves for the partial product of this cycle.
   always_comb begin
      op_x = (cnt_ff == 2'd2) ? req.a[63:32] : req.a[31:0];
      op_y = (cnt_ff == 2'd1) ? req.b[63:32] : req.b[31:0];
      part = op_x * op_y;
   end

   // Control: busy through the low product and the two cross terms, then a done pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && !req.go && (cnt_ff == 2'd2);
         if (req.go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 2'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd2) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Accumulator.
   always_ff @(posedge clock) begin
      if (busy_ff && !req.go) begin
         case (cnt_ff)
            2'd0:    acc_ff <= part;
            default: acc_ff[63:32] <= acc_ff[63:32] + part[31:0];
         endcase
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

// File: rtl/core/crws_front.sv
// Front end: takes request beats, decodes the opcode and holds the items
// in a short queue so the back end can run at its own pace.
module crws_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [crws_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               req_tuser,
   output logic                               item_valid,
   output crws_pkg::item_type                 item,
   input  logic                               item_pop
);

   crws_pkg::item_type           slot_ff [crws_pkg::QUEUE_DEPTH];
   logic [crws_pkg::QP_W-1:0]    wr_ptr_ff;
   logic [crws_pkg::QP_W-1:0]    rd_ptr_ff;
   logic [crws_pkg::QP_W:0]      count_ff;
   logic                         push;
   logic                         pop;
   crws_pkg::item_type           decoded;

   // Decode the beat into a queue item.
   always_comb begin
      decoded.is_start = (crws_pkg::opcode_type'(req_tuser) == crws_pkg::OP_START);
      decoded.seed     = req_tdata[crws_pkg::WORD_W-1:0];
   end

   assign req_tready = (count_ff != (crws_pkg::QP_W+1)'(crws_pkg::QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_pop && item_valid;

   // Queue pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == crws_pkg::QP_W'(crws_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == crws_pkg::QP_W'(crws_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: rtl/core/crws_back.sv
// Back end: runs one queued item at a time. A start item derives the
// generator words and disorder seed through the mix finalizer and hashes
// the origin; an uncapped step draws from the generator, moves the walker
// and rehashes the site. All 64-bit products use the shared multiplier.
module crws_back (
   input  logic                  clock,
   input  logic                  reset,
   input  crws_pkg::cfg_type     cfg,
   input  logic                  item_valid,
   input  crws_pkg::item_type    item,
   output logic                  item_pop,
   output crws_pkg::mul_req_type mul_req,
   input  crws_pkg::mul_rsp_type mul_rsp,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output crws_pkg::result_type  rsp
);

   localparam int W_W = crws_pkg::Y_W + 1;
   localparam logic [W_W-1:0] W_MAX = W_W'(1) << crws_pkg::Y_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAW,
      ST_MOVE,
      ST_HASH_GO,
      ST_HASH_X,
      ST_HASH_Y,
      ST_MIX_A,
      ST_MIX_B
   } state_type;

   typedef enum logic [1:0] {
      PH_KEY,
      PH_WORD,
      PH_DIS,
      PH_HASH
   } phase_type;

   state_type                         state_ff;
   phase_type                         phase_ff;
   logic [1:0]                        word_ff;
   logic [crws_pkg::WORD_W-1:0]       gen_ff [4];
   logic [crws_pkg::WORD_W-1:0]       dis_ff;
   logic [crws_pkg::WORD_W-1:0]       hash_ff;
   logic [crws_pkg::WORD_W-1:0]       seed_ff;
   logic [crws_pkg::WORD_W-1:0]       key_ff;
   logic [crws_pkg::WORD_W-1:0]       xs_ff;
   logic [crws_pkg::THR_W-1:0]        draw_ff;
   logic signed [crws_pkg::X_W-1:0]   x_ff;
   logic [crws_pkg::Y_W-1:0]          y_ff;
   logic [crws_pkg::STEP_W-1:0]       steps_ff;
   logic                              mul_go_ff;
   logic [crws_pkg::WORD_W-1:0]       mul_a_ff;
   logic [crws_pkg::WORD_W-1:0]       mul_b_ff;
   logic                              rsp_valid_ff;
   crws_pkg::result_type              rsp_ff;

   logic                              out_free;
   logic                              take;
   logic                              capped_now;
   logic                              mul_go_in;
   logic                              rsp_load;
   logic                              rsp_valid_in;
   logic [crws_pkg::WORD_W-1:0]       prod_xs;
   logic [crws_pkg::WORD_W-1:0]       key_first;
   logic [crws_pkg::WORD_W-1:0]       key_next;
   logic [crws_pkg::WORD_W-1:0]       hash_sum;
   logic [crws_pkg::WORD_W-1:0]       gen_sum;
   logic [crws_pkg::WORD_W-1:0]       gen_out;
   logic [crws_pkg::WORD_W-1:0]       s2_a;
   logic [crws_pkg::WORD_W-1:0]       s3_a;
   logic [crws_pkg::WORD_W-1:0]       s1_n;
   logic [crws_pkg::WORD_W-1:0]       s0_n;
   logic [crws_pkg::WORD_W-1:0]       s2_n;
   logic [crws_pkg::WORD_W-1:0]       s3_n;
   logic                              words_zero;
   logic [W_W-1:0]                    w_eff;
   logic [W_W-1:0]                    y_inc;
   logic [crws_pkg::Y_W-1:0]          y_up;
   logic [crws_pkg::Y_W-1:0]          y_down;
   logic signed [crws_pkg::X_W-1:0]   x_move;
   logic [crws_pkg::Y_W-1:0]          y_move;

   function automatic logic [crws_pkg::WORD_W-1:0] xs33(input logic [crws_pkg::WORD_W-1:0] z);
      return z ^ (z >> 33);
   endfunction

   // Handshake with the queue and the output register.
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign take       = (state_ff == ST_IDLE) && out_free && item_valid;
   assign item_pop   = take;
   assign capped_now = (steps_ff >= cfg.step_limit) || (steps_ff == '1);

   // A result is loaded on a capped step or when the site hash is done.
   assign rsp_load     = (take && !item.is_start && capped_now) ||
                         ((state_ff == ST_MIX_B) && mul_rsp.done && (phase_ff == PH_HASH));
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // A new product starts after each finished one, except at the end of a chain.
   assign mul_go_in = (take && item.is_start) || (state_ff == ST_HASH_GO) ||
                      (mul_rsp.done && ((state_ff == ST_HASH_X) || (state_ff == ST_HASH_Y) ||
                                        (state_ff == ST_MIX_A))) ||
                      (mul_rsp.done && (state_ff == ST_MIX_B) &&
                       ((phase_ff == PH_KEY) || (phase_ff == PH_WORD)));

   // Mixing datapath around the multiplier result.
   always_comb begin
      prod_xs    = xs33(mul_rsp.product);
      key_first  = prod_xs + crws_pkg::GOLD;
      key_next   = key_ff + crws_pkg::GOLD;
      hash_sum   = xs_ff + mul_rsp.product + dis_ff;
      words_zero = ((gen_ff[0] | gen_ff[1] | gen_ff[2] | prod_xs) == '0);
   end

   // xoshiro256++ output and state update.
   always_comb begin
      gen_sum = gen_ff[0] + gen_ff[3];
      gen_out = {gen_sum[40:0], gen_sum[63:41]} + gen_ff[0];
      s2_a    = gen_ff[2] ^ gen_ff[0];
      s3_a    = gen_ff[3] ^ gen_ff[1];
      s1_n    = gen_ff[1] ^ s2_a;
      s0_n    = gen_ff[0] ^ s3_a;
      s2_n    = s2_a ^ (gen_ff[1] << 17);
      s3_n    = {s3_a[18:0], s3_a[63:19]};
   end

   // Move selection and the transverse boundary.
   always_comb begin
      if (cfg.chan_width == '0) begin
         w_eff = W_W'(1);
      end else if (W_W'(cfg.chan_width) > W_MAX) begin
         w_eff = W_MAX;
      end else begin
         w_eff = W_W'(cfg.chan_width);
      end
      y_inc = {1'b0, y_ff} + W_W'(1);
      if (!cfg.reflect) begin
         y_up   = (y_inc >= w_eff) ? '0 : y_inc[crws_pkg::Y_W-1:0];
         y_down = (y_ff == '0) ? crws_pkg::Y_W'(w_eff - W_W'(1)) : y_ff - 1'b1;
      end else begin
         y_up   = (y_inc < w_eff) ? y_inc[crws_pkg::Y_W-1:0] : y_ff;
         y_down = (y_ff != '0) ? y_ff - 1'b1 : y_ff;
      end
      x_move = x_ff;
      y_move = y_ff;
      if (draw_ff < cfg.thr_right) begin
         x_move = x_ff + crws_pkg::X_W'(1);
      end else if (draw_ff < cfg.thr_left) begin
         x_move = x_ff - crws_pkg::X_W'(1);
      end else if (draw_ff < cfg.thr_up) begin
         y_move = y_up;
      end else begin
         y_move = y_down;
      end
   end

   // Sequencer with the walk state and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_KEY;
         word_ff      <= 2'd0;
         gen_ff[0]    <= '0;
         gen_ff[1]    <= '0;
         gen_ff[2]    <= '0;
         gen_ff[3]    <= '0;
         dis_ff       <= '0;
         hash_ff      <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         steps_ff     <= '0;
         mul_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_go_ff    <= mul_go_in;
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  if (item.is_start) begin
                     seed_ff   <= item.seed;
                     mul_a_ff  <= xs33(item.seed ^ crws_pkg::SEED_SALT);
                     mul_b_ff  <= crws_pkg::M_A;
                     phase_ff  <= PH_KEY;
                     state_ff  <= ST_MIX_A;
                  end else if (capped_now) begin
                     // Capped step: nothing moves, the cached hash still holds.
                     rsp_ff.x      <= x_ff;
                     rsp_ff.y      <= y_ff;
                     rsp_ff.steps  <= steps_ff;
                     rsp_ff.hash   <= hash_ff;
                     rsp_ff.capped <= 1'b1;
                  end else begin
                     state_ff <= ST_DRAW;
                  end
               end
            end
            ST_DRAW: begin
               draw_ff   <= {1'b0, gen_out[63:11]} + crws_pkg::THR_W'(1);
               gen_ff[0] <= s0_n;
               gen_ff[1] <= s1_n;
               gen_ff[2] <= s2_n;
               gen_ff[3] <= s3_n;
               state_ff  <= ST_MOVE;
            end
            ST_MOVE: begin
               x_ff     <= x_move;
               y_ff     <= y_move;
               steps_ff <= steps_ff + 1'b1;
               state_ff <= ST_HASH_GO;
            end
            ST_HASH_GO: begin
               mul_a_ff  <= {{(crws_pkg::WORD_W - crws_pkg::X_W){x_ff[crws_pkg::X_W-1]}}, x_ff};
               mul_b_ff  <= crws_pkg::GOLD;
               state_ff  <= ST_HASH_X;
            end
            ST_HASH_X: begin
               if (mul_rsp.done) begin
                  xs_ff     <= mul_rsp.product;
                  mul_a_ff  <= {{(crws_pkg::WORD_W - crws_pkg::Y_W){1'b0}}, y_ff};
                  mul_b_ff  <= crws_pkg::YMUL;
                  state_ff  <= ST_HASH_Y;
               end
            end
            ST_HASH_Y: begin
               if (mul_rsp.done) begin
                  mul_a_ff  <= xs33(hash_sum);
                  mul_b_ff  <= crws_pkg::M_A;
                  phase_ff  <= PH_HASH;
                  state_ff  <= ST_MIX_A;
               end
            end
            ST_MIX_A: begin
               if (mul_rsp.done) begin
                  mul_a_ff  <= prod_xs;
                  mul_b_ff  <= crws_pkg::M_B;
                  state_ff  <= ST_MIX_B;
               end
            end
            ST_MIX_B: begin
               if (mul_rsp.done) begin
                  // prod_xs is the finished mix; route it by phase.
                  unique case (phase_ff)
                     PH_KEY: begin
                        key_ff    <= key_first;
                        mul_a_ff  <= xs33(key_first);
                        mul_b_ff  <= crws_pkg::M_A;
                        word_ff   <= 2'd0;
                        phase_ff  <= PH_WORD;
                        state_ff  <= ST_MIX_A;
                     end
                     PH_WORD: begin
                        gen_ff[word_ff] <= prod_xs;
                        mul_b_ff        <= crws_pkg::M_A;
                        state_ff        <= ST_MIX_A;
                        if (word_ff != 2'd3) begin
                           key_ff   <= key_next;
                           mul_a_ff <= xs33(key_next);
                           word_ff  <= word_ff + 2'd1;
                        end else begin
                           // An all-zero generator would never leave zero.
                           if (words_zero) begin
                              gen_ff[0] <= crws_pkg::WORD_W'(1);
                           end
                           mul_a_ff <= xs33(seed_ff ^ crws_pkg::DIS_SALT);
                           phase_ff <= PH_DIS;
                        end
                     end
                     PH_DIS: begin
                        dis_ff   <= prod_xs;
                        x_ff     <= '0;
                        y_ff     <= '0;
                        steps_ff <= '0;
                        state_ff <= ST_HASH_GO;
                     end
                     PH_HASH: begin
                        hash_ff       <= prod_xs;
                        rsp_ff.x      <= x_ff;
                        rsp_ff.y      <= y_ff;
                        rsp_ff.steps  <= steps_ff;
                        rsp_ff.hash   <= prod_xs;
                        rsp_ff.capped <= 1'b0;
                        state_ff      <= ST_IDLE;
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign mul_req.go = mul_go_ff;
   assign mul_req.a  = mul_a_ff;
   assign mul_req.b  = mul_b_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp        = rsp_ff;

endmodule

// File: rtl/core/channel_random_walk_stepper.sv
// Lattice random walk in a channel, driven by a xoshiro256++ generator.
// A start beat (tuser 0) seeds the generator and the disorder seed from the
// walk seed and returns the origin; a step beat (tuser 1) moves the walker
// one site and returns the new position, step count and site hash. Every
// request beat gives exactly one response beat, in order. Items are worked
// one at a time by a sequencer that shares a single 64-bit multiplier; the
// go of the next product of a chain is registered from the last done.
// A start item mixes the key, the generator words and the disorder seed,
// then hashes the site; a step item draws, moves and hashes; a capped step
// (past the step limit) is answered from the held state. A two-entry queue
// accepts further requests while one is in work, and the response register
// holds a result until it is taken. Registers are to be written through
// the csr port while the block is idle; the block does not enforce this.
module channel_random_walk_stepper (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [crws_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [crws_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0: walk_seed[63:0].
   input  logic [crws_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // Fields from bit 0: opcode.
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // Fields from bit 0: x_position[40:0], y_position[52:41],
   // step_count[92:53], site_hash[156:93], zero fill above.
   output logic [crws_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // Fields from bit 0: capped.
   output logic                                  rsp_tuser
);

   crws_pkg::cfg_type     cfg_ff;
   logic                  item_valid;
   crws_pkg::item_type    item;
   logic                  item_pop;
   crws_pkg::mul_req_type mul_req;
   crws_pkg::mul_rsp_type mul_rsp;
   crws_pkg::result_type  result;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thr_right  <= crws_pkg::THR_RIGHT_RST;
         cfg_ff.thr_left   <= crws_pkg::THR_LEFT_RST;
         cfg_ff.thr_up     <= crws_pkg::THR_UP_RST;
         cfg_ff.chan_width <= crws_pkg::CHAN_WIDTH_RST;
         cfg_ff.reflect    <= 1'b0;
         cfg_ff.step_limit <= crws_pkg::STEP_LIMIT_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            crws_pkg::CSR_THR_RIGHT:  cfg_ff.thr_right  <= csr_wdata[crws_pkg::THR_W-1:0];
            crws_pkg::CSR_THR_LEFT:   cfg_ff.thr_left   <= csr_wdata[crws_pkg::THR_W-1:0];
            crws_pkg::CSR_THR_UP:     cfg_ff.thr_up     <= csr_wdata[crws_pkg::THR_W-1:0];
            crws_pkg::CSR_CHAN_WIDTH: cfg_ff.chan_width <= csr_wdata[crws_pkg::CW_W-1:0];
            crws_pkg::CSR_BOUNDARY:   cfg_ff.reflect    <= csr_wdata[0];
            crws_pkg::CSR_STEP_LIMIT: cfg_ff.step_limit <= csr_wdata[crws_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   crws_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   crws_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   crws_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .mul_req    (mul_req),
      .mul_rsp    (mul_rsp),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (result)
   );

   // Pack the response beat.
   assign rsp_tdata = {{crws_pkg::RSP_PAD_W{1'b0}}, result.hash, result.steps,
                       result.y, result.x};
   assign rsp_tuser = result.capped;

endmodule

// File: dv/channel_random_walk_stepper_test.sv
module channel_random_walk_stepper_test;
   import crws_pkg::*;

   localparam int RESET_CYCLES    = 6;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 120;
   localparam int IDLE_PERCENT    = 18;
   // Beat counts between which neither side idles.
   localparam int CALM_FROM       = 700;
   localparam int CALM_TO         = 900;
   // The receiver holds off once, after this many response beats.
   localparam int HOLD_AFTER      = 1100;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_CYCLES    = 100;
   localparam int QUIET_LIMIT     = 4000;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 3'd7;
   localparam logic [THR_W-1:0]     FRACTION_ONE    = 54'h20000000000000;
   localparam logic [STEP_W-1:0]    STEP_MAX        = '1;

   typedef struct packed {
      opcode_type        op;
      logic [WORD_W-1:0] seed;
   } walk_item_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;

   // Walker state and register copies kept alongside the block.
   logic [WORD_W-1:0]        gen_w [4];
   logic [WORD_W-1:0]        dis_seed;
   logic signed [WORD_W-1:0] walker_x;
   logic [Y_W-1:0]           walker_y;
   logic [STEP_W-1:0]        walker_steps;
   cfg_type                  walk_cfg;

   walk_item_type walk_items_pending [$];
   result_type    walk_results_due   [$];

   int unsigned req_beats    = 0;
   int unsigned rsp_beats    = 0;
   int unsigned start_beats  = 0;
   int unsigned step_beats   = 0;
   int unsigned capped_seen  = 0;
   int unsigned reg_writes   = 0;
   int unsigned mismatches   = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_left    = 0;
   bit          hold_done    = 1'b0;

   channel_random_walk_stepper u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [WORD_W-1:0] mix64(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] z;
      z = v;
      z = z ^ (z >> 33);
      z = z * M_A;
      z = z ^ (z >> 33);
      z = z * M_B;
      z = z ^ (z >> 33);
      return z;
   endfunction

   function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v, input int k);
      return (v << k) | (v >> (WORD_W - k));
   endfunction

   // One xoshiro256++ output; advances the generator words.
   function automatic logic [WORD_W-1:0] next_draw();
      logic [WORD_W-1:0] out;
      logic [WORD_W-1:0] t;
      out = rotl64(gen_w[0] + gen_w[3], 23) + gen_w[0];
      t = gen_w[1] << 17;
      gen_w[2] = gen_w[2] ^ gen_w[0];
      gen_w[3] = gen_w[3] ^ gen_w[1];
      gen_w[1] = gen_w[1] ^ gen_w[2];
      gen_w[0] = gen_w[0] ^ gen_w[3];
      gen_w[2] = gen_w[2] ^ t;
      gen_w[3] = rotl64(gen_w[3], 45);
      return out;
   endfunction

   function automatic logic [WORD_W-1:0] site_key();
      logic [WORD_W-1:0] xs;
      logic [WORD_W-1:0] ys;
      xs = $unsigned(walker_x) * GOLD;
      ys = {{(WORD_W-Y_W){1'b0}}, walker_y} * YMUL;
      return mix64(xs + ys + dis_seed);
   endfunction

   // Applies one accepted request beat to the walker and queues its result.
   function automatic void advance_walker(input walk_item_type item);
      logic [WORD_W-1:0] k;
      logic [WORD_W-1:0] draw;
      logic [THR_W-1:0]  r;
      logic [CW_W-1:0]   w;
      logic              capped;
      result_type        res;
      capped = 1'b0;
      if (item.op == OP_START) begin
         k = mix64(item.seed ^ SEED_SALT);
         for (int i = 0; i < 4; i++) begin
            k = k + GOLD;
            gen_w[i] = mix64(k);
         end
         // An all-zero generator would never leave zero.
         if ((gen_w[0] | gen_w[1] | gen_w[2] | gen_w[3]) == '0) begin
            gen_w[0] = 64'd1;
         end
         dis_seed = mix64(item.seed ^ DIS_SALT);
         walker_x = '0;
         walker_y = '0;
         walker_steps = '0;
         start_beats++;
      end else begin
         step_beats++;
         if (walker_steps >= walk_cfg.step_limit || walker_steps >= STEP_MAX) begin
            capped = 1'b1;
         end else begin
            draw = next_draw();
            r = {1'b0, draw[63:11]} + 54'd1;
            w = walk_cfg.chan_width;
            if (w == '0) begin
               w = 13'd1;
            end
            if (w > 13'd4096) begin
               w = 13'd4096;
            end
            // The first threshold test that passes picks the move.
            if (r < walk_cfg.thr_right) begin
               walker_x = walker_x + 1;
            end else if (r < walk_cfg.thr_left) begin
               walker_x = walker_x - 1;
            end else if (r < walk_cfg.thr_up) begin
               if (!walk_cfg.reflect) begin
                  walker_y = ({1'b0, walker_y} + 13'd1 >= w) ? '0 : walker_y + 12'd1;
               end else if ({1'b0, walker_y} + 13'd1 < w) begin
                  walker_y = walker_y + 12'd1;
               end
            end else begin
               if (!walk_cfg.reflect) begin
                  walker_y = (walker_y == '0) ? 12'(w - 13'd1) : walker_y - 12'd1;
               end else if (walker_y != '0) begin
                  walker_y = walker_y - 12'd1;
               end
            end
            walker_steps = walker_steps + 1'b1;
         end
      end
      res.x      = walker_x[X_W-1:0];
      res.y      = walker_y;
      res.steps  = walker_steps;
      res.hash   = site_key();
      res.capped = capped;
      walk_results_due.insert(walk_results_due.size(), res);
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Mostly a uniform fraction below one, sometimes an extreme.
   function automatic logic [THR_W-1:0] pick_threshold();
      logic [WORD_W-1:0] rand_word;
      rand_word = random_word();
      case ($urandom_range(0, 9))
         0: begin
            return '0;
         end
         1: begin
            return FRACTION_ONE;
         end
         2: begin
            return '1;
         end
         default: begin
            return {1'b0, rand_word[52:0]};
         end
      endcase
   endfunction

   function automatic bit take_idle(input int unsigned beats);
      if (beats >= CALM_FROM && beats < CALM_TO) begin
         return 1'b0;
      end
      return $urandom_range(0, 99) < IDLE_PERCENT;
   endfunction

   function automatic void offer_walk_item(input opcode_type op, input logic [WORD_W-1:0] seed);
      walk_item_type item;
      item.op   = op;
      item.seed = seed;
      walk_items_pending.insert(walk_items_pending.size(), item);
   endfunction

   // Register write through the csr port; the local copy follows the same masking.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_THR_RIGHT: begin
            walk_cfg.thr_right = value[THR_W-1:0];
         end
         CSR_THR_LEFT: begin
            walk_cfg.thr_left = value[THR_W-1:0];
         end
         CSR_THR_UP: begin
            walk_cfg.thr_up = value[THR_W-1:0];
         end
         CSR_CHAN_WIDTH: begin
            walk_cfg.chan_width = value[CW_W-1:0];
         end
         CSR_BOUNDARY: begin
            walk_cfg.reflect = value[0];
         end
         CSR_STEP_LIMIT: begin
            walk_cfg.step_limit = value[STEP_W-1:0];
         end
         default: begin
         end
      endcase
      reg_writes++;
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   task automatic wait_drained();
      while (walk_items_pending.size() != 0 || walk_results_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic void check_walk_result();
      result_type               want;
      logic signed [X_W-1:0]    got_x;
      logic [Y_W-1:0]           got_y;
      logic [STEP_W-1:0]        got_steps;
      logic [WORD_W-1:0]        got_hash;
      logic [RSP_PAD_W-1:0]     got_pad;
      got_x     = rsp_tdata[X_W-1:0];
      got_y     = rsp_tdata[X_W +: Y_W];
      got_steps = rsp_tdata[X_W+Y_W +: STEP_W];
      got_hash  = rsp_tdata[X_W+Y_W+STEP_W +: WORD_W];
      got_pad   = rsp_tdata[RSP_TDATA_W-1:RSP_FIELDS_W];
      rsp_beats++;
      if (walk_results_due.size() == 0) begin
         $error("response beat with no result due: tdata %h, tuser %b", rsp_tdata, rsp_tuser);
         mismatches++;
         return;
      end
      want = walk_results_due.pop_front();
      if (want.capped) begin
         capped_seen++;
      end
      if (got_x !== want.x) begin
         $error("x_position: expected %0d, got %0d", want.x, got_x);
         mismatches++;
      end
      if (got_y !== want.y) begin
         $error("y_position: expected %0d, got %0d", want.y, got_y);
         mismatches++;
      end
      if (got_steps !== want.steps) begin
         $error("step_count: expected %0d, got %0d", want.steps, got_steps);
         mismatches++;
      end
      if (got_hash !== want.hash) begin
         $error("site_hash: expected %h, got %h", want.hash, got_hash);
         mismatches++;
      end
      if (rsp_tuser !== want.capped) begin
         $error("capped: expected %b, got %b", want.capped, rsp_tuser);
         mismatches++;
      end
      if (got_pad !== '0) begin
         $error("tdata fill: expected %0d, got %0d", 0, got_pad);
         mismatches++;
      end
   endfunction

   // Request driver: presents the oldest pending item and predicts on each accepted beat.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_walker(walk_items_pending.pop_front());
            req_beats++;
         end
         if (!req_tvalid || req_tready) begin
            if (walk_items_pending.size() != 0 && !take_idle(req_beats)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= walk_items_pending[0].seed;
               req_tuser  <= walk_items_pending[0].op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each beat and paces tready, with one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_walk_result();
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && rsp_beats >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !take_idle(rsp_beats);
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      logic [THR_W-1:0]  t0;
      logic [THR_W-1:0]  t1;
      logic [THR_W-1:0]  t2;
      logic [THR_W-1:0]  tmp;
      logic [CW_W-1:0]   width;
      logic [STEP_W-1:0] limit;
      logic [WORD_W-1:0] junk;
      logic [WORD_W-1:0] rand_word;
      gen_w[0] = '0;
      gen_w[1] = '0;
      gen_w[2] = '0;
      gen_w[3] = '0;
      dis_seed = '0;
      walker_x = '0;
      walker_y = '0;
      walker_steps = '0;
      walk_cfg.thr_right  = THR_RIGHT_RST;
      walk_cfg.thr_left   = THR_LEFT_RST;
      walk_cfg.thr_up     = THR_UP_RST;
      walk_cfg.chan_width = CHAN_WIDTH_RST;
      walk_cfg.reflect    = 1'b0;
      walk_cfg.step_limit = STEP_LIMIT_RST;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: steps on the all-zero generator, then seeds at both extremes.
      offer_walk_item(OP_STEP, '0);
      offer_walk_item(OP_STEP, '1);
      offer_walk_item(OP_START, '0);
      offer_walk_item(OP_START, '1);
      offer_walk_item(OP_STEP, random_word());
      offer_walk_item(OP_STEP, random_word());
      wait_drained();

      // Every draw moves up, with the up threshold above one; the walker wraps at width 5.
      write_csr(CSR_THR_RIGHT, '0);
      write_csr(CSR_THR_LEFT, '0);
      write_csr(CSR_THR_UP, '1);
      write_csr(CSR_CHAN_WIDTH, 54'd5);
      write_csr(CSR_BOUNDARY, 54'd0);
      write_csr(CSR_STEP_LIMIT, {14'd0, STEP_MAX});
      offer_walk_item(OP_START, random_word());
      repeat (8) offer_walk_item(OP_STEP, random_word());
      wait_drained();

      // Channel narrowed under the walker: a reflecting up move is blocked.
      write_csr(CSR_CHAN_WIDTH, 54'd2);
      write_csr(CSR_BOUNDARY, 54'd1);
      write_csr(CSR_UNMAPPED_LO, '1);
      write_csr(CSR_UNMAPPED_HI, '1);
      repeat (2) offer_walk_item(OP_STEP, random_word());
      wait_drained();

      // Periodic up move from outside the channel goes to zero.
      write_csr(CSR_BOUNDARY, 54'd0);
      offer_walk_item(OP_STEP, random_word());
      wait_drained();

      // Down moves in the widest channel, the width field above the clamp.
      write_csr(CSR_THR_UP, '0);
      write_csr(CSR_CHAN_WIDTH, 54'h1FFF);
      repeat (2) offer_walk_item(OP_STEP, random_word());
      wait_drained();

      // Width zero counts as one; a reflecting down move from outside still steps.
      write_csr(CSR_CHAN_WIDTH, 54'd0);
      write_csr(CSR_BOUNDARY, 54'd1);
      offer_walk_item(OP_STEP, random_word());
      wait_drained();

      // Thresholds out of order and a small step limit that caps the walk.
      write_csr(CSR_THR_RIGHT, 54'h10000000000000);
      write_csr(CSR_THR_LEFT, 54'h08000000000000);
      write_csr(CSR_THR_UP, FRACTION_ONE);
      write_csr(CSR_CHAN_WIDTH, 54'd5);
      write_csr(CSR_BOUNDARY, 54'd0);
      write_csr(CSR_STEP_LIMIT, 54'd3);
      offer_walk_item(OP_START, random_word());
      repeat (5) offer_walk_item(OP_STEP, random_word());
      wait_drained();

      // Random settings, each followed by walks of random steps and occasional restarts.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         t0 = pick_threshold();
         t1 = pick_threshold();
         t2 = pick_threshold();
         if ($urandom_range(0, 3) != 0) begin
            if (t0 > t1) begin
               tmp = t0; t0 = t1; t1 = tmp;
            end
            if (t1 > t2) begin
               tmp = t1; t1 = t2; t2 = tmp;
            end
            if (t0 > t1) begin
               tmp = t0; t0 = t1; t1 = tmp;
            end
         end
         case ($urandom_range(0, 7))
            0: begin
               width = 13'd0;
            end
            1: begin
               width = 13'd4096;
            end
            2: begin
               width = 13'h1FFF;
            end
            3: begin
               width = 13'd1;
            end
            default: begin
               width = 13'($urandom_range(2, 9));
            end
         endcase
         rand_word = random_word();
         case ($urandom_range(0, 7))
            0: begin
               limit = '0;
            end
            1: begin
               limit = STEP_MAX;
            end
            2, 3: begin
               limit = 40'($urandom_range(0, 60));
            end
            4: begin
               limit = STEP_LIMIT_RST;
            end
            default: begin
               limit = rand_word[STEP_W-1:0];
            end
         endcase
         // Bits above each register's width carry noise half the time.
         junk = $urandom_range(0, 1) ? random_word() : '0;
         write_csr(CSR_THR_RIGHT, t0);
         write_csr(CSR_THR_LEFT, t1);
         write_csr(CSR_THR_UP, t2);
         write_csr(CSR_CHAN_WIDTH, {junk[40:0], width});
         write_csr(CSR_BOUNDARY, {junk[52:0], 1'($urandom_range(0, 1))});
         write_csr(CSR_STEP_LIMIT, {junk[13:0], limit});
         if ($urandom_range(0, 3) != 0) begin
            offer_walk_item(OP_START, random_word());
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 99) < 8) begin
               offer_walk_item(OP_START, random_word());
            end else begin
               offer_walk_item(OP_STEP, random_word());
            end
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Covered %0d start and %0d step beats, %0d of the steps capped at the limit.",
               start_beats, step_beats, capped_seen);
      $display("Register writes: %0d, over %0d random settings and the directed corner cases.",
               reg_writes, RANDOM_PHASES);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/crws_pkg.sv
rtl/core/crws_mul.sv
rtl/core/crws_front.sv
rtl/core/crws_back.sv
rtl/core/channel_random_walk_stepper.sv
dv/channel_random_walk_stepper_test.sv
